// ===== rtl/core/mbps_pkg.sv =====
// Shared constants, types and register codes of the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int ADDR_WIDTH  = 32;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OCCURRENCE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET       = 3'd6;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

    typedef struct packed {
        window_t                 pattern;
        logic [MAX_PATTERN-1:0]  care_mask;
        logic [LEN_W-1:0]        length;
        logic [CNT_W-1:0]        occurrence;
        logic [ADDR_WIDTH-1:0]   base;
        logic [ADDR_WIDTH-1:0]   offset;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_t;

endpackage

// ===== rtl/core/mbps_config.sv =====
// Configuration register file of the masked byte pattern scanner.
`timescale 1ns / 1ps

module mbps_config (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output mbps_pkg::cfg_t                    cfg
);
    import mbps_pkg::*;

    logic [63:0]             pattern_low_reg;
    logic [63:0]             pattern_high_reg;
    logic [MAX_PATTERN-1:0]  care_mask_reg;
    logic [LEN_W-1:0]        length_reg;
    logic [CNT_W-1:0]        occurrence_reg;
    logic [ADDR_WIDTH-1:0]   base_reg;
    logic [ADDR_WIDTH-1:0]   offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '1;
            length_reg       <= LEN_W'(1);
            occurrence_reg   <= '0;
            base_reg         <= '0;
            offset_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_wdata[63:0];
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_wdata[63:0];
                REG_CARE_MASK:    care_mask_reg    <= cfg_wdata[MAX_PATTERN-1:0];
                REG_LENGTH:       length_reg       <= cfg_wdata[LEN_W-1:0];
                REG_OCCURRENCE:   occurrence_reg   <= cfg_wdata[CNT_W-1:0];
                REG_BASE:         base_reg         <= cfg_wdata[ADDR_WIDTH-1:0];
                REG_OFFSET:       offset_reg       <= cfg_wdata[ADDR_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.pattern    = window_t'({pattern_high_reg, pattern_low_reg});
    assign cfg.care_mask  = care_mask_reg;
    assign cfg.length     = length_reg;
    assign cfg.occurrence = occurrence_reg;
    assign cfg.base       = base_reg;
    assign cfg.offset     = offset_reg;

endmodule

// ===== rtl/core/mbps_window.sv =====
// Input register and sliding byte window of the masked byte pattern scanner.
`timescale 1ns / 1ps

module mbps_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_ready,
    input  logic [mbps_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    input  logic                          stage_fire,
    output mbps_pkg::stage_t              stage,
    output mbps_pkg::window_t             window
);
    import mbps_pkg::*;

    logic    valid_reg;
    logic    last_reg;
    window_t window_reg;
    logic    accept;

    assign byte_ready = !valid_reg || stage_fire;
    assign accept     = byte_valid && byte_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            window_reg <= '0;
        end
        else if (accept)
        begin
            valid_reg  <= 1'b1;
            last_reg   <= last_byte;
            window_reg <= window_t'({window_reg, data_byte});
        end
        else if (stage_fire)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.last  = last_reg;
    assign window      = window_reg;

endmodule

// ===== rtl/core/mbps_match.sv =====
// Window compare, region counters and result register of the masked byte pattern scanner.
`timescale 1ns / 1ps

module mbps_match (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mbps_pkg::cfg_t                    cfg,
    input  mbps_pkg::stage_t                  stage,
    input  mbps_pkg::window_t                 window,
    output logic                              stage_fire,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              found,
    output logic [mbps_pkg::ADDR_WIDTH-1:0]   match_address
);
    import mbps_pkg::*;

    logic [ADDR_WIDTH-1:0] pos_reg;
    logic [LEN_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      match_cnt_reg;
    logic                  reported_reg;
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;

    logic [LEN_W-1:0]      used_len;
    logic [LEN_W-1:0]      fill_next;
    logic [LEN_W-1:0]      tap;
    logic [ADDR_WIDTH-1:0] count;
    logic [ADDR_WIDTH-1:0] addr_calc;
    logic                  window_ok;
    logic                  hit;
    logic                  take;
    logic                  produce;

    always_comb
    begin
        if (cfg.length == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (cfg.length > LEN_W'(MAX_PATTERN))
        begin
            used_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            used_len = cfg.length;
        end
    end

    always_comb
    begin
        window_ok = 1'b1;
        tap       = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            tap = used_len - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < used_len) && cfg.care_mask[i] &&
                (window[tap[IDX_W-1:0]] != cfg.pattern[i]))
            begin
                window_ok = 1'b0;
            end
        end
    end

    assign fill_next = (fill_reg == LEN_W'(MAX_PATTERN)) ? fill_reg : fill_reg + LEN_W'(1);
    assign count     = pos_reg + ADDR_WIDTH'(1);
    assign addr_calc = cfg.base + (count - ADDR_WIDTH'(used_len)) + cfg.offset;

    assign hit        = !reported_reg && (fill_next >= used_len) && window_ok;
    assign take       = hit && (match_cnt_reg == cfg.occurrence);
    assign produce    = take || (stage.last && !reported_reg);
    assign stage_fire = stage.valid && (!produce || !out_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            match_cnt_reg <= '0;
            reported_reg  <= 1'b0;
        end
        else if (stage_fire)
        begin
            if (stage.last)
            begin
                pos_reg       <= '0;
                fill_reg      <= '0;
                match_cnt_reg <= '0;
                reported_reg  <= 1'b0;
            end
            else
            begin
                pos_reg  <= count;
                fill_reg <= fill_next;
                if (take)
                begin
                    reported_reg <= 1'b1;
                end
                else if (hit && (match_cnt_reg != '1))
                begin
                    match_cnt_reg <= match_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && produce)
        begin
            found_reg <= take;
            addr_reg  <= take ? addr_calc : '0;
        end
    end

    assign result_valid  = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

endmodule

// ===== rtl/core/masked_byte_pattern_scanner.sv =====
// An accepted byte is held in the window register, then its result in the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the combinational window compare.
// A result waiting at the output stalls the input only when the next byte also yields a result.
// Reset is asynchronous and active low; it clears the window, counters and valid flags at once.
// Configuration registers return to their documented defaults on reset.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_ready,
    input  logic [mbps_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              last_byte,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              found,
    output logic [mbps_pkg::ADDR_WIDTH-1:0]   match_address,
    input  logic                              cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mbps_pkg::*;

    cfg_t    cfg;
    stage_t  stage;
    window_t window;
    logic    stage_fire;

    mbps_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mbps_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .stage_fire (stage_fire),
        .stage      (stage),
        .window     (window)
    );

    mbps_match u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .stage         (stage),
        .window        (window),
        .stage_fire    (stage_fire),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .found         (found),
        .match_address (match_address)
    );

endmodule

// ===== rtl/core/mbps_checker.sv =====
// Port-level checker of the masked byte pattern scanner and its bind.
`timescale 1ns / 1ps

module mbps_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              byte_valid,
    input logic                              byte_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic                              found,
    input logic [mbps_pkg::ADDR_WIDTH-1:0]   match_address
);
    import mbps_pkg::*;

    // A stalled result beat holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(found) && $stable(match_address))
        else $error("result beat changed while stalled");

    // A miss always reports a zero address.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> match_address == '0)
        else $error("miss result carries a nonzero address");

    // With the output register empty an offered byte beat is always taken.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !result_valid |-> byte_ready)
        else $error("input stalled while the output register is empty");

    // Nothing is presented in the first cycle after reset.
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !result_valid)
        else $error("result beat right after reset");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .found         (found),
    .match_address (match_address)
);
